>>> src/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg: shared types and constants for the multipart boundary deframer
// Boundary sizing, event codes, line characters and the window control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mbd_pkg;

    localparam int MAX_BOUNDARY = 128;
    localparam int IDX_W        = $clog2(MAX_BOUNDARY);
    localparam int CNT_W        = $clog2(MAX_BOUNDARY + 1);

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_DASH = 8'h2D;

    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_BEGIN = 2'd1,
        EV_END   = 2'd2,
        EV_ERROR = 2'd3
    } event_t;

    // control from the parser to the window/boundary store
    typedef struct packed {
        logic             bnd_we;
        logic [IDX_W-1:0] bnd_idx;
        logic             win_we;
        logic             win_shift;
        logic [IDX_W-1:0] win_idx;
        logic [IDX_W-1:0] last_idx;
        logic [CNT_W-1:0] size;
    } win_ctl_t;

endpackage

`default_nettype wire

>>> src/mbd_if.sv
// ----------------------------------------------------------------------------
// mbd_if: valid/ready channels of the multipart boundary deframer
// One interface for body bytes, one for result events.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface mbd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] data_byte;
    logic       last_part;

    modport source (output valid, output event_res, output data_byte, output last_part,
                    input ready);
    modport sink (input valid, input event_res, input data_byte, input last_part,
                  output ready);
endinterface

`default_nettype wire

>>> src/mbd_window.sv
// ----------------------------------------------------------------------------
// mbd_window: boundary store, sliding payload window and parallel compare
// Computes the updated window for the current byte and compares all entries
// below the boundary size against the boundary at once.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_window import mbd_pkg::*;
(
    input  wire logic       clk,
    input  wire win_ctl_t   ctl,
    input  wire logic [7:0] din,
    output logic [7:0]      oldest,
    output logic            hit
);

    logic [7:0]              bnd_reg  [MAX_BOUNDARY];
    logic [7:0]              win_reg  [MAX_BOUNDARY];
    logic [7:0]              win_next [MAX_BOUNDARY];
    logic [7:0]              upper    [MAX_BOUNDARY];
    logic [7:0]              bnd_ref  [MAX_BOUNDARY];
    logic [MAX_BOUNDARY-1:0] eq;

    always_comb
    begin
        for (int i = 0; i < MAX_BOUNDARY - 1; i++)
        begin
            upper[i] = win_reg[i+1];
        end
        upper[MAX_BOUNDARY-1] = din;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_BOUNDARY; i++)
        begin
            // CR LF prefix is fixed; the rest comes from the boundary line
            if (i == 0)
            begin
                bnd_ref[i] = CHAR_CR;
            end
            else if (i == 1)
            begin
                bnd_ref[i] = CHAR_LF;
            end
            else
            begin
                bnd_ref[i] = bnd_reg[i];
            end

            if (ctl.win_shift)
            begin
                win_next[i] = (IDX_W'(i) == ctl.last_idx) ? din : upper[i];
            end
            else
            begin
                win_next[i] = (IDX_W'(i) == ctl.win_idx) ? din : win_reg[i];
            end

            // entries beyond the boundary take no part in the compare
            eq[i] = (win_next[i] == bnd_ref[i]) || (CNT_W'(i) >= ctl.size);
        end
    end

    assign hit    = &eq;
    assign oldest = win_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctl.win_we)
        begin
            win_reg <= win_next;
        end
        if (ctl.bnd_we)
        begin
            bnd_reg[ctl.bnd_idx] <= din;
        end
    end

endmodule

`default_nettype wire

>>> src/multipart_boundary_deframer.sv
// ----------------------------------------------------------------------------
// multipart_boundary_deframer: splits a multipart body into part events
// Learns the boundary from the first line, skips part headers, releases
// payload bytes through a boundary-sized window and decodes the trailer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  body     in   valid/ready   in_byte
//  events   out  valid/ready   event_res, data_byte, last_part
//  cfg      in   cfg_wr_en     cfg_wr_data (content_length)
//
//  One body byte per cycle; its event, if any, is registered and shows in
//  the cycle after accept. The throughput is set by the combinational window
//  compare over all MAX_BOUNDARY entries. Bytes are taken whenever the result
//  register is empty or being drained, so a stalled sink stops input only
//  when a result waits. Reset clears the length to zero; a content_length
//  write restarts parsing at the boundary line with the programmed length.
// ----------------------------------------------------------------------------
`default_nettype none

module multipart_boundary_deframer import mbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    mbd_in_if.sink           body,
    mbd_out_if.source        events
);

    typedef enum logic [2:0] {
        PH_BOUNDARY = 3'd0,
        PH_HEADER   = 3'd1,
        PH_DATA     = 3'd2,
        PH_TRAILER  = 3'd3,
        PH_DONE     = 3'd4,
        PH_ERROR    = 3'd5
    } phase_t;

    phase_t           phase_reg,   phase_next;
    logic [31:0]      left_reg,    left_next;
    logic [CNT_W-1:0] size_reg,    size_next;
    logic [CNT_W-1:0] fill_reg,    fill_next;
    logic             cr_reg,      cr_next;
    logic             line_reg,    line_next;
    logic [1:0]       tc_reg,      tc_next;
    logic             dash_reg,    dash_next;
    logic             final_reg,   final_next;

    logic             ovalid_reg;
    event_t           ev_reg,      ev_next;
    logic [7:0]       data_reg,    data_next;
    logic             last_reg,    last_next;
    logic             res_valid;

    logic             accept;
    logic [7:0]       c;
    win_ctl_t         wctl;
    logic [7:0]       oldest;
    logic             hit;

    assign c      = body.in_byte;
    assign accept = body.valid && body.ready;
    assign body.ready = !ovalid_reg || events.ready;

    mbd_window u_window
    (
        .clk    (clk),
        .ctl    (wctl),
        .din    (c),
        .oldest (oldest),
        .hit    (hit)
    );

    always_comb
    begin
        logic       dropped;
        logic       is_eol;
        logic       is_char;
        logic       check;
        logic       released;
        logic [1:0] tc_inc;

        phase_next = phase_reg;
        left_next  = left_reg;
        size_next  = size_reg;
        fill_next  = fill_reg;
        cr_next    = cr_reg;
        line_next  = line_reg;
        tc_next    = tc_reg;
        dash_next  = dash_reg;
        final_next = final_reg;
        res_valid  = 1'b0;
        ev_next    = EV_DATA;
        data_next  = 8'd0;
        last_next  = 1'b0;

        wctl.bnd_we    = 1'b0;
        wctl.bnd_idx   = size_reg[IDX_W-1:0];
        wctl.win_we    = 1'b0;
        wctl.win_shift = 1'b0;
        wctl.win_idx   = fill_reg[IDX_W-1:0];
        wctl.last_idx  = IDX_W'(size_reg - CNT_W'(1));
        wctl.size      = size_reg;

        dropped  = !cr_reg && (c == CHAR_CR);
        is_eol   = !dropped && (c == CHAR_LF);
        is_char  = !dropped && (c != CHAR_LF);
        check    = 1'b0;
        released = 1'b0;
        tc_inc   = tc_reg + 2'd1;

        if (phase_reg == PH_DONE)
        begin
            // ignore trailing bytes
        end
        else if (phase_reg == PH_ERROR || phase_reg > PH_ERROR || left_reg == 32'd0)
        begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            ev_next    = EV_ERROR;
        end
        else
        begin
            left_next = left_reg - 32'd1;
            unique case (phase_reg)
                PH_BOUNDARY:
                begin
                    cr_next = dropped;
                    if (is_char && size_reg < CNT_W'(MAX_BOUNDARY))
                    begin
                        wctl.bnd_we = 1'b1;
                        size_next   = size_reg + CNT_W'(1);
                    end
                    else if (is_eol)
                    begin
                        phase_next = PH_HEADER;
                        line_next  = 1'b0;
                    end
                end
                PH_HEADER:
                begin
                    cr_next = dropped;
                    if (is_char)
                    begin
                        line_next = 1'b1;
                    end
                    else if (is_eol)
                    begin
                        if (line_reg)
                        begin
                            line_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                            fill_next  = '0;
                            res_valid  = 1'b1;
                            ev_next    = EV_BEGIN;
                        end
                    end
                end
                PH_DATA:
                begin
                    wctl.win_we = 1'b1;
                    if (fill_reg < size_reg)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                        check     = (fill_reg + CNT_W'(1)) >= size_reg;
                    end
                    else
                    begin
                        wctl.win_shift = 1'b1;
                        check          = 1'b1;
                        released       = 1'b1;
                    end

                    if (check && hit)
                    begin
                        if (left_next < 32'd2)
                        begin
                            phase_next = PH_ERROR;
                            res_valid  = 1'b1;
                            ev_next    = EV_ERROR;
                        end
                        else
                        begin
                            phase_next = PH_TRAILER;
                            tc_next    = 2'd0;
                            dash_next  = 1'b0;
                            final_next = 1'b0;
                            if (released)
                            begin
                                res_valid = 1'b1;
                                data_next = oldest;
                            end
                        end
                    end
                    else if (left_next == 32'd0)
                    begin
                        phase_next = PH_ERROR;
                        res_valid  = 1'b1;
                        ev_next    = EV_ERROR;
                    end
                    else if (released)
                    begin
                        res_valid = 1'b1;
                        data_next = oldest;
                    end
                end
                PH_TRAILER:
                begin
                    if (final_reg)
                    begin
                        tc_next = tc_inc;
                        if (tc_inc >= 2'd2)
                        begin
                            phase_next = PH_DONE;
                            final_next = 1'b0;
                            tc_next    = 2'd0;
                            res_valid  = 1'b1;
                            ev_next    = EV_END;
                            last_next  = 1'b1;
                        end
                    end
                    else if (tc_reg == 2'd0)
                    begin
                        dash_next = (c == CHAR_DASH);
                        tc_next   = 2'd1;
                    end
                    else
                    begin
                        tc_next = 2'd0;
                        if ((dash_reg && c == CHAR_DASH) || left_next <= 32'd2)
                        begin
                            if (left_next != 32'd2)
                            begin
                                phase_next = PH_ERROR;
                                res_valid  = 1'b1;
                                ev_next    = EV_ERROR;
                            end
                            else
                            begin
                                final_next = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                            line_next  = 1'b0;
                            cr_next    = 1'b0;
                            res_valid  = 1'b1;
                            ev_next    = EV_END;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_ERROR;
                end
            endcase
        end

        // hold the stores while no byte is taken or a length is written
        if (!accept || cfg_wr_en)
        begin
            wctl.bnd_we = 1'b0;
            wctl.win_we = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_BOUNDARY;
            left_reg   <= 32'd0;
            size_reg   <= CNT_W'(2);
            fill_reg   <= '0;
            cr_reg     <= 1'b0;
            line_reg   <= 1'b0;
            tc_reg     <= 2'd0;
            dash_reg   <= 1'b0;
            final_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (accept && !cfg_wr_en && res_valid)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (events.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                // restart parsing with the new length
                phase_reg  <= PH_BOUNDARY;
                left_reg   <= cfg_wr_data;
                size_reg   <= CNT_W'(2);
                fill_reg   <= '0;
                cr_reg     <= 1'b0;
                line_reg   <= 1'b0;
                tc_reg     <= 2'd0;
                dash_reg   <= 1'b0;
                final_reg  <= 1'b0;
            end
            else if (accept)
            begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
                size_reg  <= size_next;
                fill_reg  <= fill_next;
                cr_reg    <= cr_next;
                line_reg  <= line_next;
                tc_reg    <= tc_next;
                dash_reg  <= dash_next;
                final_reg <= final_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !cfg_wr_en && res_valid)
        begin
            ev_reg   <= ev_next;
            data_reg <= data_next;
            last_reg <= last_next;
        end
    end

    assign events.valid     = ovalid_reg;
    assign events.event_res = ev_reg;
    assign events.data_byte = data_reg;
    assign events.last_part = last_reg;

    property p_window_bound;
        @(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (fill_reg <= size_reg);
    endproperty
    assert property (p_window_bound)
        else $error("window fill beyond boundary size");

    property p_size_range;
        @(posedge clk) disable iff (!rst_n)
        (size_reg >= CNT_W'(2)) && (size_reg <= CNT_W'(MAX_BOUNDARY));
    endproperty
    assert property (p_size_range)
        else $error("boundary size out of range");

    property p_error_sticky;
        @(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERROR && !cfg_wr_en) |=> (phase_reg == PH_ERROR);
    endproperty
    assert property (p_error_sticky)
        else $error("error phase left without restart");

    property p_done_silent;
        @(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE && accept && !cfg_wr_en && !events.ready && !ovalid_reg)
            |=> !ovalid_reg;
    endproperty
    assert property (p_done_silent)
        else $error("result produced after final part");

endmodule

`default_nettype wire
